@@ rtl/hsl_pkg.sv @@
package hsl_pkg;

	// Channel rebuild scale: one grey step is GreyUnit, full scale is FullD.
	localparam int unsigned GreyUnit = 130560;
	localparam int unsigned FullD    = 33292800;
	localparam int unsigned BrightK  = 130050;

	// Reciprocal of 255 scaled by 2^23, exact for 16-bit dividends.
	localparam int unsigned Recip255 = 32897;

	// Register byte addresses.
	localparam logic [2:0] AddrBright = 3'd0;
	localparam logic [2:0] AddrSat    = 3'd4;

	// Result of the analysis stages, carried toward the rebuild stage.
	typedef struct packed {
		logic        grey;
		logic [7:0]  mx;
		logic [7:0]  l;
		logic [10:0] h;
	} hsl_t;

endpackage

@@ rtl/hsl_div.sv @@
// Small restoring divider over two register stages.
// It computes quo = floor(num / den) for num < 2^19, den < 2^10, with the quotient
// known to fit in 10 bits. The first stage resolves quotient bits 9 to 5, the
// second stage bits 4 to 0, so each stage holds five narrow compare-subtract steps.
module hsl_div (
	input  logic        clk,
	input  logic        en,
	input  logic [18:0] num,
	input  logic [9:0]  den,
	output logic [9:0]  quo
);
	logic [4:0]  qhi_c;
	logic [18:0] rem_c;
	logic [19:0] trial_c;
	logic [4:0]  qhi_s1;
	logic [18:0] rem_s1;
	logic [9:0]  den_s1;
	logic [4:0]  qlo_c;
	logic [18:0] reml_c;
	logic [19:0] triall_c;

	// Upper quotient bits.
	always_comb begin
		rem_c = num;
		qhi_c = '0;
		for (int i = 9; i >= 5; i--) begin
			trial_c = {1'b0, rem_c} - ({10'd0, den} << i);
			if (!trial_c[19]) begin
				rem_c = trial_c[18:0];
				qhi_c[i - 5] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qhi_s1 <= qhi_c;
			rem_s1 <= rem_c;
			den_s1 <= den;
		end
	end

	// Lower quotient bits from the partial remainder.
	always_comb begin
		reml_c = rem_s1;
		qlo_c = '0;
		for (int i = 4; i >= 0; i--) begin
			triall_c = {1'b0, reml_c} - ({10'd0, den_s1} << i);
			if (!triall_c[19]) begin
				reml_c = triall_c[18:0];
				qlo_c[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= {qhi_s1, qlo_c};
		end
	end
endmodule

@@ rtl/hsl_rebuild.sv @@
// Rebuilds one channel from HSL and applies brightness with clamping and rounding.
// The first stage forms the clamped, rounded channel value divided by 512; the
// second stage divides it by 255 through a reciprocal multiplication.
module hsl_rebuild (
	input  logic               clk,
	input  logic               en,
	input  logic [1:0]         role,
	input  logic [8:0]         f,
	input  logic               grey,
	input  logic [7:0]         mx,
	input  logic [7:0]         l,
	input  logic [16:0]        cn,
	input  logic signed [9:0]  bright,
	output logic [7:0]         ch
);
	import hsl_pkg::*;

	logic signed [33:0] mid0;
	logic signed [33:0] v_c;
	logic signed [33:0] clamp_c;
	logic [15:0]        t_c;
	logic [15:0]        t_s1;
	logic [30:0]        prod_c;

	// Roles: 0 low, 1 high, 2 rising with f, 3 falling with 256-f.
	always_comb begin
		mid0 = 34'(l) * 34'(GreyUnit);
		unique case (role)
			2'd0: v_c = mid0 - 34'(cn) * 34'sd256;
			2'd1: v_c = mid0 + 34'(cn) * 34'sd256;
			2'd2: v_c = mid0 - 34'(cn) * 34'sd256 + 34'(cn) * 34'(2 * f);
			default: v_c = mid0 - 34'(cn) * 34'sd256 + 34'(cn) * 34'(2 * (9'd256 - f));
		endcase
		if (grey) v_c = 34'(mx) * 34'(GreyUnit);
		v_c = v_c + 34'(bright) * 34'(BrightK);
		clamp_c = v_c;
		if (v_c < 0) clamp_c = '0;
		else if (v_c > $signed(34'(FullD))) clamp_c = $signed(34'(FullD));
		// One grey step is 255 * 512: add half a step, then drop the factor of 512.
		t_c = 16'((clamp_c + 34'(GreyUnit / 2)) >> 9);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_c;
		end
	end

	// Division by 255 is exact for every dividend below 65536 with this reciprocal.
	always_comb begin
		prod_c = 31'(t_s1) * 31'(Recip255);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch <= prod_c[30:23];
		end
	end
endmodule

@@ rtl/hsl_saturation_brightness_adjust.sv @@
// HSL saturation and brightness adjust.
// Input stream s_axis carries one RGB pixel per transaction: tdata [7:0] red,
// [15:8] green, [23:16] blue. Output stream m_axis carries the adjusted pixel in
// the same layout. The APB port holds two registers: brightness_offset at 0x0
// and saturation_offset at 0x4, each 10-bit signed, reset to zero.
// The pipeline has six register stages: min/max and lightness, two stages of
// the saturation and hue dividers, the saturation offset and chroma product,
// and two stages of channel rebuild with brightness and rounding. Throughput
// is one pixel per clock while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds; s_axis_tready follows
// the output side so no pixel is lost or repeated.
// Reset clears all valid bits and both registers.
module hsl_saturation_brightness_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hsl_pkg::*;

	logic signed [9:0] bright_q, sat_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en;

	// Pipeline advances when the output slot is empty or being taken.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= '0;
			sat_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == AddrBright) bright_q <= pwdata[9:0];
			else if (paddr == AddrSat) sat_q <= pwdata[9:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == AddrBright) prdata = 32'(bright_q);
		else if (paddr == AddrSat) prdata = 32'(sat_q);
	end

	// Stage 1: extremes, lightness, dividends.
	logic [7:0] r, g, b, mx_c, mn_c;
	logic [8:0] d_c, sum_c, den_c;
	logic signed [9:0] diff_c;
	logic [10:0] base_c;
	logic [7:0] mx_s1, l_s1;
	logic [8:0] d_s1, den_s1;
	logic [18:0] snum_s1, hnum_s1;
	logic [10:0] base_s1;
	logic grey_s1;
	assign r = s_axis_tdata[7:0];
	assign g = s_axis_tdata[15:8];
	assign b = s_axis_tdata[23:16];
	always_comb begin
		mx_c = r; mn_c = r;
		if (g > mx_c) mx_c = g;
		if (b > mx_c) mx_c = b;
		if (g < mn_c) mn_c = g;
		if (b < mn_c) mn_c = b;
		d_c = 9'(mx_c) - 9'(mn_c);
		sum_c = 9'(mx_c) + 9'(mn_c);
		den_c = (sum_c < 9'd255) ? sum_c : 9'(10'd510 - 10'(sum_c));
		if (mx_c == r) begin diff_c = 10'(g) - 10'(b); base_c = 11'd0; end
		else if (mx_c == g) begin diff_c = 10'(b) - 10'(r); base_c = 11'd512; end
		else begin diff_c = 10'(r) - 10'(g); base_c = 11'd1024; end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx_c;
			l_s1 <= 8'((10'(sum_c) + 10'd1) >> 1);
			d_s1 <= d_c;
			den_s1 <= den_c;
			grey_s1 <= (d_c == 9'd0);
			snum_s1 <= 19'(510 * d_c) + 19'(den_c);
			hnum_s1 <= 19'(19'(512) * 19'(10'(diff_c) + 10'(d_c))) + 19'(d_c);
			base_s1 <= base_c;
		end
	end

	// Stages 2 and 3: saturation and hue dividers, side data delayed to match.
	logic [9:0] sq_s3, hq_s3;
	logic [7:0] mx_s2, l_s2, mx_s3, l_s3;
	logic [10:0] base_s2, base_s3;
	logic grey_s2, grey_s3;
	hsl_div u_sdiv (.clk, .en, .num(snum_s1),
		.den(grey_s1 ? 10'd2 : {den_s1, 1'b0}), .quo(sq_s3));
	hsl_div u_hdiv (.clk, .en, .num(hnum_s1),
		.den(grey_s1 ? 10'd2 : {d_s1, 1'b0}), .quo(hq_s3));
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= mx_s1; l_s2 <= l_s1; base_s2 <= base_s1; grey_s2 <= grey_s1;
			mx_s3 <= mx_s2; l_s3 <= l_s2; base_s3 <= base_s2; grey_s3 <= grey_s2;
		end
	end

	// Stage 4: offset saturation, hue, chroma product.
	logic signed [11:0] soff_c, s_c;
	logic [11:0] h_c;
	logic signed [9:0] tl_c;
	logic [7:0] a_c, s8_c;
	hsl_t p_s4;
	logic [16:0] cn_s4;
	always_comb begin
		soff_c = 12'(((20'(sat_q) * 20'sd255 + 20'sd128 + 20'sd131072) >>> 8) - 20'sd512);
		s_c = 12'(sq_s3) + soff_c;
		if (s_c < 0) s8_c = 8'd0;
		else if (s_c > 12'sd255) s8_c = 8'd255;
		else s8_c = s_c[7:0];
		h_c = 12'(base_s3) + 12'(hq_s3) + 12'd1280;
		if (h_c >= 12'd1536) h_c = h_c - 12'd1536;
		tl_c = 10'(2 * l_s3) - 10'sd255;
		a_c = 8'(10'sd255 - (tl_c < 0 ? -tl_c : tl_c));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= '{grey: grey_s3, mx: mx_s3, l: l_s3, h: h_c[10:0]};
			cn_s4 <= 17'(a_c) * 17'(s8_c);
		end
	end

	// Stages 5 and 6: role selection per sextant and channel rebuild.
	logic [1:0] rr, rg, rb;
	always_comb begin
		unique case (p_s4.h[10:8])
			3'd0: begin rr = 2'd1; rg = 2'd2; rb = 2'd0; end
			3'd1: begin rr = 2'd3; rg = 2'd1; rb = 2'd0; end
			3'd2: begin rr = 2'd0; rg = 2'd1; rb = 2'd2; end
			3'd3: begin rr = 2'd0; rg = 2'd3; rb = 2'd1; end
			3'd4: begin rr = 2'd2; rg = 2'd0; rb = 2'd1; end
			default: begin rr = 2'd1; rg = 2'd0; rb = 2'd3; end
		endcase
	end
	hsl_rebuild u_r (.clk, .en, .role(rr), .f({1'b0, p_s4.h[7:0]}), .grey(p_s4.grey),
		.mx(p_s4.mx), .l(p_s4.l), .cn(cn_s4), .bright(bright_q), .ch(m_axis_tdata[7:0]));
	hsl_rebuild u_g (.clk, .en, .role(rg), .f({1'b0, p_s4.h[7:0]}), .grey(p_s4.grey),
		.mx(p_s4.mx), .l(p_s4.l), .cn(cn_s4), .bright(bright_q), .ch(m_axis_tdata[15:8]));
	hsl_rebuild u_b (.clk, .en, .role(rb), .f({1'b0, p_s4.h[7:0]}), .grey(p_s4.grey),
		.mx(p_s4.mx), .l(p_s4.l), .cn(cn_s4), .bright(bright_q), .ch(m_axis_tdata[23:16]));

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end
	assign m_axis_tvalid = v_s6;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s5 |=> m_axis_tvalid) else $error("pipeline lost transaction");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("stalled while empty");
`endif
endmodule
